// ----- design/bcpp_pkg.sv -----
// Shared constants, types and width helpers for the box corner projector.
`timescale 1ns / 1ps

package bcpp_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    localparam int FOCAL_W       = 16;
    localparam int HALF_SCREEN_W = 12;
    localparam int SIZE_W        = 12;
    localparam int HALF_SIZE_W   = 11;
    localparam int FRAC_BITS     = 8;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [FOCAL_W-1:0]       FOCAL_RESET = 16'd600;
    localparam logic [HALF_SCREEN_W-1:0] HSW_RESET   = 12'd500;
    localparam logic [HALF_SCREEN_W-1:0] HSH_RESET   = 12'd325;

    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HSW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HSH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CAM_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CAM_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CAM_Z = 3'd5;

    localparam logic [2:0] LAST_CORNER = 3'd7;

    // Width of a corner coordinate: centre plus camera offset plus half size.
    function automatic int coord_pw(input int w);
        return ((w > 19) ? w : 19) + 2;
    endfunction

    // Quotient bits kept by the divider; larger quotients clamp and still
    // saturate the same way once the screen offset is added.
    function automatic int quot_bits(input int w);
        return ((w + 1) > 21) ? (w + 1) : 21;
    endfunction

    // Sign of the half-size offset per corner: bit 2 is x, bit 1 y, bit 0 z.
    function automatic logic [2:0] corner_sign(input logic [2:0] idx);
        logic [2:0] s;
        case (idx)
            3'd0:    s = 3'b000;
            3'd1:    s = 3'b111;
            3'd2:    s = 3'b101;
            3'd3:    s = 3'b110;
            3'd4:    s = 3'b011;
            3'd5:    s = 3'b100;
            3'd6:    s = 3'b001;
            3'd7:    s = 3'b010;
            default: s = 3'b000;
        endcase
        return s;
    endfunction

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic       last;
        logic       ok;
        logic       neg_x;
        logic       neg_y;
    } tag_t;

endpackage

// ----- design/bcpp_intf.sv -----
// Box input and corner output channel interfaces.
`timescale 1ns / 1ps

interface bcpp_in_if #(parameter int COORD_WIDTH = bcpp_pkg::COORD_WIDTH_DEF);
    logic                             valid;
    logic                             ready;
    logic signed [COORD_WIDTH-1:0]    centre_x;
    logic signed [COORD_WIDTH-1:0]    centre_y;
    logic signed [COORD_WIDTH-1:0]    centre_z;
    logic [bcpp_pkg::SIZE_W-1:0]      size_x;
    logic [bcpp_pkg::SIZE_W-1:0]      size_y;
    logic [bcpp_pkg::SIZE_W-1:0]      size_z;

    modport source (
        output valid, centre_x, centre_y, centre_z, size_x, size_y, size_z,
        input  ready
    );
    modport sink (
        input  valid, centre_x, centre_y, centre_z, size_x, size_y, size_z,
        output ready
    );
endinterface

interface bcpp_out_if #(parameter int COORD_WIDTH = bcpp_pkg::COORD_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    corner_index;
    logic                          corner_valid;
    logic signed [COORD_WIDTH-1:0] screen_x;
    logic signed [COORD_WIDTH-1:0] screen_y;
    logic                          last_corner;

    modport source (
        output valid, corner_index, corner_valid, screen_x, screen_y, last_corner,
        input  ready
    );
    modport sink (
        input  valid, corner_index, corner_valid, screen_x, screen_y, last_corner,
        output ready
    );
endinterface

// ----- design/bcpp_corner_gen.sv -----
// Corner sequencer: holds one box and issues its eight corners, one per cycle while adv is high.
`timescale 1ns / 1ps

module bcpp_corner_gen #(
    parameter int COORD_WIDTH = bcpp_pkg::COORD_WIDTH_DEF,
    localparam int PW = bcpp_pkg::coord_pw(COORD_WIDTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    bcpp_in_if.sink                       box,
    input  logic signed [COORD_WIDTH-1:0] cam_x,
    input  logic signed [COORD_WIDTH-1:0] cam_y,
    input  logic signed [COORD_WIDTH-1:0] cam_z,
    output logic signed [PW-1:0]          px,
    output logic signed [PW-1:0]          py,
    output logic signed [PW-1:0]          pz,
    output bcpp_pkg::tag_t                tag
);

    localparam int BW  = COORD_WIDTH + 1;
    localparam int HW  = bcpp_pkg::HALF_SIZE_W;
    localparam int FB  = bcpp_pkg::FRAC_BITS;
    localparam int PAD = PW - HW - FB;

    logic                   busy_reg, busy_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic signed [BW-1:0]   bx_reg, by_reg, bz_reg;
    logic [HW-1:0]          hx_reg, hy_reg, hz_reg;
    logic signed [PW-1:0]   px_reg, py_reg, pz_reg;
    logic signed [PW-1:0]   px_next, py_next, pz_next;
    bcpp_pkg::tag_t         tag_reg, tag_next;
    logic                   accept;
    logic [2:0]             sign;
    logic signed [PW-1:0]   bx_ext, by_ext, bz_ext;
    logic signed [PW-1:0]   hx_ext, hy_ext, hz_ext;

    // A new box is taken while idle or in the cycle its predecessor issues its last corner.
    assign box.ready = adv && (!busy_reg || (cnt_reg == bcpp_pkg::LAST_CORNER));
    assign accept    = box.valid && box.ready;

    assign sign   = bcpp_pkg::corner_sign(cnt_reg);
    assign bx_ext = {{(PW-BW){bx_reg[BW-1]}}, bx_reg};
    assign by_ext = {{(PW-BW){by_reg[BW-1]}}, by_reg};
    assign bz_ext = {{(PW-BW){bz_reg[BW-1]}}, bz_reg};
    assign hx_ext = {{PAD{1'b0}}, hx_reg, {FB{1'b0}}};
    assign hy_ext = {{PAD{1'b0}}, hy_reg, {FB{1'b0}}};
    assign hz_ext = {{PAD{1'b0}}, hz_reg, {FB{1'b0}}};

    assign px_next = sign[2] ? (bx_ext + hx_ext) : (bx_ext - hx_ext);
    assign py_next = sign[1] ? (by_ext + hy_ext) : (by_ext - hy_ext);
    assign pz_next = sign[0] ? (bz_ext + hz_ext) : (bz_ext - hz_ext);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        tag_next  = '0;
        if (busy_reg)
        begin
            tag_next.valid = 1'b1;
            tag_next.index = cnt_reg;
            tag_next.last  = (cnt_reg == bcpp_pkg::LAST_CORNER);
            cnt_next       = 3'(cnt_reg + 3'd1);
            if (cnt_reg == bcpp_pkg::LAST_CORNER)
            begin
                busy_next = 1'b0;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            tag_reg  <= '0;
        end
        else if (adv)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            tag_reg  <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bx_reg <= $signed({box.centre_x[COORD_WIDTH-1], box.centre_x})
                    + $signed({cam_x[COORD_WIDTH-1], cam_x});
            by_reg <= $signed({box.centre_y[COORD_WIDTH-1], box.centre_y})
                    + $signed({cam_y[COORD_WIDTH-1], cam_y});
            bz_reg <= $signed({box.centre_z[COORD_WIDTH-1], box.centre_z})
                    + $signed({cam_z[COORD_WIDTH-1], cam_z});
            hx_reg <= box.size_x[bcpp_pkg::SIZE_W-1:1];
            hy_reg <= box.size_y[bcpp_pkg::SIZE_W-1:1];
            hz_reg <= box.size_z[bcpp_pkg::SIZE_W-1:1];
        end
        if (adv)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
    end

    assign px  = px_reg;
    assign py  = py_reg;
    assign pz  = pz_reg;
    assign tag = tag_reg;

endmodule

// ----- design/bcpp_scale.sv -----
// Scaling stages: focal multiply, depth check, then sign split into magnitudes.
`timescale 1ns / 1ps

module bcpp_scale #(
    parameter int COORD_WIDTH = bcpp_pkg::COORD_WIDTH_DEF,
    localparam int PW = bcpp_pkg::coord_pw(COORD_WIDTH),
    localparam int MW = PW + 15,
    localparam int DW = PW - 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  bcpp_pkg::tag_t                 tag_in,
    input  logic signed [PW-1:0]           px,
    input  logic signed [PW-1:0]           py,
    input  logic signed [PW-1:0]           pz,
    input  logic [bcpp_pkg::FOCAL_W-1:0]   focal,
    output bcpp_pkg::tag_t                 tag_out,
    output logic [MW-1:0]                  mag_x,
    output logic [MW-1:0]                  mag_y,
    output logic [DW-1:0]                  dsr
);

    localparam int PRW = PW + bcpp_pkg::FOCAL_W + 1;

    logic signed [PRW-1:0] prod_x_reg, prod_y_reg;
    logic signed [PRW-1:0] prod_x_next, prod_y_next;
    logic signed [PW-1:0]  depth_reg;
    logic signed [PRW-1:0] abs_x, abs_y;
    logic [MW-1:0]         mag_x_reg, mag_y_reg;
    logic [DW-1:0]         dsr_reg, dsr_next;
    bcpp_pkg::tag_t        s2_tag_reg, s2_tag_next;
    bcpp_pkg::tag_t        s3_tag_reg, s3_tag_next;

    assign prod_x_next = $signed(px) * $signed({1'b0, focal});
    assign prod_y_next = $signed(py) * $signed({1'b0, focal});

    always_comb
    begin
        s2_tag_next    = tag_in;
        s2_tag_next.ok = !pz[PW-1] && (pz != '0);
    end

    assign abs_x = prod_x_reg[PRW-1] ? -prod_x_reg : prod_x_reg;
    assign abs_y = prod_y_reg[PRW-1] ? -prod_y_reg : prod_y_reg;

    // A corner that will be dropped still gets a harmless divisor of one.
    assign dsr_next = s2_tag_reg.ok ? depth_reg[DW-1:0] : DW'(1);

    always_comb
    begin
        s3_tag_next       = s2_tag_reg;
        s3_tag_next.neg_x = prod_x_reg[PRW-1];
        s3_tag_next.neg_y = prod_y_reg[PRW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else if (adv)
        begin
            s2_tag_reg <= s2_tag_next;
            s3_tag_reg <= s3_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            depth_reg  <= pz;
            mag_x_reg  <= abs_x[MW-1:0];
            mag_y_reg  <= abs_y[MW-1:0];
            dsr_reg    <= dsr_next;
        end
    end

    assign tag_out = s3_tag_reg;
    assign mag_x   = mag_x_reg;
    assign mag_y   = mag_y_reg;
    assign dsr     = dsr_reg;

endmodule

// ----- design/bcpp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage for the x and y lanes.
`timescale 1ns / 1ps

module bcpp_div #(
    parameter int COORD_WIDTH = bcpp_pkg::COORD_WIDTH_DEF,
    localparam int PW = bcpp_pkg::coord_pw(COORD_WIDTH),
    localparam int MW = PW + 15,
    localparam int DW = PW - 1,
    localparam int K  = bcpp_pkg::quot_bits(COORD_WIDTH)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  bcpp_pkg::tag_t tag_in,
    input  logic [MW-1:0]  mag_x,
    input  logic [MW-1:0]  mag_y,
    input  logic [DW-1:0]  dsr,
    output bcpp_pkg::tag_t tag_out,
    output logic [K-1:0]   q_x,
    output logic [K-1:0]   q_y
);

    localparam int AW = MW + bcpp_pkg::FRAC_BITS;
    localparam int TW = AW - K;
    localparam int CW = TW + DW;

    logic [AW-1:0]  dvd_x, dvd_y;
    logic [CW-1:0]  top_x_cmp, top_y_cmp, dsr_cmp;

    logic [DW-1:0]  rem_x_reg  [0:K];
    logic [DW-1:0]  rem_y_reg  [0:K];
    logic [K-1:0]   work_x_reg [0:K];
    logic [K-1:0]   work_y_reg [0:K];
    logic           ovf_x_reg  [0:K];
    logic           ovf_y_reg  [0:K];
    logic [DW-1:0]  dsr_reg    [0:K];
    bcpp_pkg::tag_t tag_reg    [0:K];

    // The eight fraction bits of the dividend are zero; the high part checks
    // whether the quotient would overflow the kept bits.
    assign dvd_x     = {mag_x, {bcpp_pkg::FRAC_BITS{1'b0}}};
    assign dvd_y     = {mag_y, {bcpp_pkg::FRAC_BITS{1'b0}}};
    assign top_x_cmp = {{DW{1'b0}}, dvd_x[AW-1:K]};
    assign top_y_cmp = {{DW{1'b0}}, dvd_y[AW-1:K]};
    assign dsr_cmp   = {{TW{1'b0}}, dsr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (adv)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_x_reg[0]  <= top_x_cmp[DW-1:0];
            rem_y_reg[0]  <= top_y_cmp[DW-1:0];
            work_x_reg[0] <= dvd_x[K-1:0];
            work_y_reg[0] <= dvd_y[K-1:0];
            ovf_x_reg[0]  <= (top_x_cmp >= dsr_cmp);
            ovf_y_reg[0]  <= (top_y_cmp >= dsr_cmp);
            dsr_reg[0]    <= dsr;
        end
    end

    genvar i;
    generate
        for (i = 0; i < K; i++)
        begin : g_stage
            logic [DW:0]   sh_x, sh_y;
            logic [DW:0]   dsr_ext;
            logic [DW:0]   diff_x, diff_y;
            logic          ge_x, ge_y;
            logic [DW-1:0] rem_x_next, rem_y_next;

            assign dsr_ext    = {1'b0, dsr_reg[i]};
            assign sh_x       = {rem_x_reg[i], work_x_reg[i][K-1]};
            assign sh_y       = {rem_y_reg[i], work_y_reg[i][K-1]};
            assign ge_x       = (sh_x >= dsr_ext);
            assign ge_y       = (sh_y >= dsr_ext);
            assign diff_x     = sh_x - dsr_ext;
            assign diff_y     = sh_y - dsr_ext;
            assign rem_x_next = ge_x ? diff_x[DW-1:0] : sh_x[DW-1:0];
            assign rem_y_next = ge_y ? diff_y[DW-1:0] : sh_y[DW-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[i+1] <= '0;
                end
                else if (adv)
                begin
                    tag_reg[i+1] <= tag_reg[i];
                end
            end

            // Dividend bits leave the top of the work word as quotient bits enter below.
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_x_reg[i+1]  <= rem_x_next;
                    rem_y_reg[i+1]  <= rem_y_next;
                    work_x_reg[i+1] <= {work_x_reg[i][K-2:0], ge_x};
                    work_y_reg[i+1] <= {work_y_reg[i][K-2:0], ge_y};
                    ovf_x_reg[i+1]  <= ovf_x_reg[i];
                    ovf_y_reg[i+1]  <= ovf_y_reg[i];
                    dsr_reg[i+1]    <= dsr_reg[i];
                end
            end
        end
    endgenerate

    assign tag_out = tag_reg[K];
    assign q_x     = ovf_x_reg[K] ? {K{1'b1}} : work_x_reg[K];
    assign q_y     = ovf_y_reg[K] ? {K{1'b1}} : work_y_reg[K];

endmodule

// ----- design/bcpp_skid.sv -----
// Two-entry output buffer that decouples the pipeline from the result channel.
`timescale 1ns / 1ps

module bcpp_skid #(
    parameter int COORD_WIDTH = bcpp_pkg::COORD_WIDTH_DEF,
    localparam int DATA_W = 2 * COORD_WIDTH + 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  logic [DATA_W-1:0] push_data,
    output logic              can_push,
    bcpp_out_if.source        corner
);

    localparam int W = COORD_WIDTH;

    logic              out_valid_reg, skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg, skid_data_reg;
    logic              push, pop;

    assign can_push = !skid_valid_reg;
    assign push     = push_valid && can_push;
    assign pop      = out_valid_reg && corner.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign corner.valid        = out_valid_reg;
    assign corner.corner_index = out_data_reg[2*W+4:2*W+2];
    assign corner.corner_valid = out_data_reg[2*W+1];
    assign corner.screen_x     = out_data_reg[2*W:W+1];
    assign corner.screen_y     = out_data_reg[W:1];
    assign corner.last_corner  = out_data_reg[0];

endmodule

// ----- design/box_corner_perspective_projector_top.sv -----
// Box corner perspective projector: top level with registers and output stages.
// Each accepted box passes the corner sequencer, scaling stages, divider and output stages.
// Throughput: one corner word per cycle while the output buffer has a free entry, set by the
// corner sequencer, which takes a new box as the last corner of the previous box issues.
// Reset restores the default focal distance, screen centre and zero camera offset.
`timescale 1ns / 1ps

module box_corner_perspective_projector_top #(
    parameter int COORD_WIDTH = bcpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bcpp_in_if.sink                          box,
    bcpp_out_if.source                       corner,
    input  logic                             cfg_wr_en,
    input  logic [bcpp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]           cfg_wdata
);

    localparam int W   = COORD_WIDTH;
    localparam int PW  = bcpp_pkg::coord_pw(W);
    localparam int MW  = PW + 15;
    localparam int DW  = PW - 1;
    localparam int K   = bcpp_pkg::quot_bits(W);
    localparam int SW  = K + 2;
    localparam int HSW = bcpp_pkg::HALF_SCREEN_W;
    localparam int FB  = bcpp_pkg::FRAC_BITS;
    localparam int DATA_W = 2 * W + 5;

    logic [bcpp_pkg::FOCAL_W-1:0] focal_reg;
    logic [HSW-1:0]               hsw_reg, hsh_reg;
    logic signed [W-1:0]          cam_x_reg, cam_y_reg, cam_z_reg;

    logic                 adv;
    logic signed [PW-1:0] px, py, pz;
    bcpp_pkg::tag_t       gen_tag, scale_tag, div_tag;
    logic [MW-1:0]        mag_x, mag_y;
    logic [DW-1:0]        dsr;
    logic [K-1:0]         q_x, q_y;

    logic signed [K:0]    qs_x_reg, qs_y_reg;
    bcpp_pkg::tag_t       f1_tag_reg, f2_tag_reg;
    logic [SW-1:0]        sum_x, sum_y;
    logic [W-1:0]         sx_reg, sy_reg, sx_next, sy_next;
    logic [DATA_W-1:0]    push_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg <= bcpp_pkg::FOCAL_RESET;
            hsw_reg   <= bcpp_pkg::HSW_RESET;
            hsh_reg   <= bcpp_pkg::HSH_RESET;
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bcpp_pkg::REG_FOCAL: focal_reg <= cfg_wdata[bcpp_pkg::FOCAL_W-1:0];
                bcpp_pkg::REG_HSW:   hsw_reg   <= cfg_wdata[HSW-1:0];
                bcpp_pkg::REG_HSH:   hsh_reg   <= cfg_wdata[HSW-1:0];
                bcpp_pkg::REG_CAM_X: cam_x_reg <= cfg_wdata;
                bcpp_pkg::REG_CAM_Y: cam_y_reg <= cfg_wdata;
                bcpp_pkg::REG_CAM_Z: cam_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bcpp_corner_gen #(.COORD_WIDTH(W)) u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .box   (box),
        .cam_x (cam_x_reg),
        .cam_y (cam_y_reg),
        .cam_z (cam_z_reg),
        .px    (px),
        .py    (py),
        .pz    (pz),
        .tag   (gen_tag)
    );

    bcpp_scale #(.COORD_WIDTH(W)) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (gen_tag),
        .px      (px),
        .py      (py),
        .pz      (pz),
        .focal   (focal_reg),
        .tag_out (scale_tag),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .dsr     (dsr)
    );

    bcpp_div #(.COORD_WIDTH(W)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (scale_tag),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .dsr     (dsr),
        .tag_out (div_tag),
        .q_x     (q_x),
        .q_y     (q_y)
    );

    function automatic logic [W-1:0] sat_coord(input logic [SW-1:0] v);
        logic [SW-W:0] upper;
        upper = v[SW-1:W-1];
        if ((&upper) || !(|upper))
        begin
            return v[W-1:0];
        end
        return v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    assign sum_x = {qs_x_reg[K], qs_x_reg} + {{(SW-HSW-FB){1'b0}}, hsw_reg, {FB{1'b0}}};
    assign sum_y = {qs_y_reg[K], qs_y_reg} + {{(SW-HSW-FB){1'b0}}, hsh_reg, {FB{1'b0}}};
    assign sx_next = f1_tag_reg.ok ? sat_coord(sum_x) : '0;
    assign sy_next = f1_tag_reg.ok ? sat_coord(sum_y) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_tag_reg <= '0;
            f2_tag_reg <= '0;
        end
        else if (adv)
        begin
            f1_tag_reg <= div_tag;
            f2_tag_reg <= f1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qs_x_reg <= div_tag.neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
            qs_y_reg <= div_tag.neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
        end
    end

    assign push_data = {f2_tag_reg.index, f2_tag_reg.ok, sx_reg, sy_reg, f2_tag_reg.last};

    // The whole pipeline moves only while the output buffer has a free entry.
    bcpp_skid #(.COORD_WIDTH(W)) u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f2_tag_reg.valid),
        .push_data  (push_data),
        .can_push   (adv),
        .corner     (corner)
    );

endmodule
